// ===== design/tbdac_pkg.sv =====
// package: widths, reset values and register indexes of the two-button angle control
`default_nettype none

package tbdac_pkg;

    localparam int TIME_W     = 16;
    localparam int ANGLE_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = 16'd50000;
    localparam logic [ANGLE_W-1:0] STEP_RESET     = 8'd10;
    localparam logic [ANGLE_W-1:0] MAX_RESET      = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET    = 8'd90;
    localparam logic [TIME_W-1:0]  TIMER_MAX      = 16'hFFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  debounce_us;
        logic [ANGLE_W-1:0] step_size;
        logic [ANGLE_W-1:0] angle_max;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/tbdac_if.sv =====
// interfaces: poll channel and result channel with valid/ready handshake
`default_nettype none

interface tbdac_poll_if
    import tbdac_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              up_level;
    logic              down_level;
    logic [TIME_W-1:0] elapsed_us;

    modport source (output valid, output up_level, output down_level, output elapsed_us,
                    input ready);
    modport sink   (input valid, input up_level, input down_level, input elapsed_us,
                    output ready);
endinterface

interface tbdac_result_if
    import tbdac_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;
    logic               up_press;
    logic               down_press;

    modport source (output valid, output angle, output up_press, output down_press,
                    input ready);
    modport sink   (input valid, input angle, input up_press, input down_press,
                    output ready);
endinterface

`default_nettype wire

// ===== design/tbdac_debounce.sv =====
// single button debouncer: quiet timer, previous raw level and stable level
`default_nettype none

module tbdac_debounce
    import tbdac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              update,
    input  wire logic              raw,
    input  wire logic [TIME_W-1:0] elapsed_us,
    input  wire logic [TIME_W-1:0] debounce_us,
    output logic                   press
);

    logic              prev_raw_reg;
    logic              stable_reg;
    logic [TIME_W-1:0] quiet_reg;
    logic [TIME_W-1:0] quiet_next;
    logic [TIME_W:0]   quiet_sum;
    logic              take_level;

    // quiet timer: clear on a level change, otherwise accumulate with saturation
    always_comb
    begin
        quiet_sum = {1'b0, quiet_reg} + {1'b0, elapsed_us};
        if (raw != prev_raw_reg)
        begin
            quiet_next = '0;
        end
        else if (quiet_sum[TIME_W])
        begin
            quiet_next = TIMER_MAX;
        end
        else
        begin
            quiet_next = quiet_sum[TIME_W-1:0];
        end
    end

    // accept the raw level once quiet long enough; falling stable level is a press
    assign take_level = (quiet_next >= debounce_us) && (raw != stable_reg);
    assign press      = take_level && !raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b1;
            stable_reg   <= 1'b1;
            quiet_reg    <= '0;
        end
        else if (update)
        begin
            prev_raw_reg <= raw;
            quiet_reg    <= quiet_next;
            if (take_level)
            begin
                stable_reg <= raw;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/tbdac_angle.sv =====
// angle register with step add/subtract and clamp to 0..angle_max
`default_nettype none

module tbdac_angle
    import tbdac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update,
    input  wire logic               up_press,
    input  wire logic               down_press,
    input  wire cfg_t               cfg,
    output logic [ANGLE_W-1:0]      angle_next
);

    localparam int SUM_W = ANGLE_W + 2;

    logic [ANGLE_W-1:0]      angle_reg;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] max_ext;
    logic signed [SUM_W-1:0] angle_sum;

    // signed sum of the step moves, then clamp
    always_comb
    begin
        step_ext  = $signed({2'b00, cfg.step_size});
        max_ext   = $signed({2'b00, cfg.angle_max});
        angle_sum = $signed({2'b00, angle_reg});
        if (up_press)
        begin
            angle_sum = angle_sum + step_ext;
        end
        if (down_press)
        begin
            angle_sum = angle_sum - step_ext;
        end
        if (angle_sum > max_ext)
        begin
            angle_next = cfg.angle_max;
        end
        else if (angle_sum < 0)
        begin
            angle_next = '0;
        end
        else
        begin
            angle_next = angle_sum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= ANGLE_RESET;
        end
        else if (update)
        begin
            angle_reg <= angle_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/two_button_debounced_angle_control.sv =====
// top level: two debounced buttons stepping a clamped angle, one result per poll
// path: a poll is held in the input register, then passes the update into the result register
//   and is offered from there; it waits in either register while the result channel stalls
// throughput: one poll per cycle unless stalled; single update pass between registers
// reset: angle 90, both buttons released with cleared quiet timers, registers at
//   debounce 50000 us, step 10, max 180; both channels empty
`default_nettype none

module two_button_debounced_angle_control
    import tbdac_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    tbdac_poll_if.sink                 poll,
    tbdac_result_if.source             result
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic               in_up_reg;
    logic               in_down_reg;
    logic [TIME_W-1:0]  in_elapsed_reg;
    logic               out_valid_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic               out_up_reg;
    logic               out_down_reg;
    logic               out_free;
    logic               advance;
    logic               poll_take;
    logic               up_press;
    logic               down_press;
    logic [ANGLE_W-1:0] angle_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_us <= DEBOUNCE_RESET;
            cfg_reg.step_size   <= STEP_RESET;
            cfg_reg.angle_max   <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_US: cfg_reg.debounce_us <= cfg_data;
                CFG_STEP_SIZE:   cfg_reg.step_size   <= cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_MAX:   cfg_reg.angle_max   <= cfg_data[ANGLE_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // handshake between input register and result register
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign poll.ready = !in_valid_reg || out_free;
    assign poll_take  = poll.valid && poll.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (poll_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            in_up_reg      <= poll.up_level;
            in_down_reg    <= poll.down_level;
            in_elapsed_reg <= poll.elapsed_us;
        end
    end

    // per-button debouncers and the angle update
    tbdac_debounce u_up_deb (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (advance),
        .raw         (in_up_reg),
        .elapsed_us  (in_elapsed_reg),
        .debounce_us (cfg_reg.debounce_us),
        .press       (up_press)
    );

    tbdac_debounce u_down_deb (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (advance),
        .raw         (in_down_reg),
        .elapsed_us  (in_elapsed_reg),
        .debounce_us (cfg_reg.debounce_us),
        .press       (down_press)
    );

    tbdac_angle u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .up_press   (up_press),
        .down_press (down_press),
        .cfg        (cfg_reg),
        .angle_next (angle_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_angle_reg <= angle_next;
            out_up_reg    <= up_press;
            out_down_reg  <= down_press;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.angle      = out_angle_reg;
    assign result.up_press   = out_up_reg;
    assign result.down_press = out_down_reg;

endmodule

`default_nettype wire

// ===== design/tbdac_checker.sv =====
// port-level checker for the angle control top level, attached by bind
`default_nettype none

module tbdac_checker
    import tbdac_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [ANGLE_W-1:0] out_angle,
    input wire logic               out_up,
    input wire logic               out_down
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_angle)
            && $stable(out_up) && $stable(out_down))
        else $error("stalled result changed");

    // a fresh result follows a poll transaction that went through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a poll transaction");

    // poll side stalls only while a result waits on a stalled result side
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("poll stalled without back pressure");

endmodule

bind two_button_debounced_angle_control tbdac_checker u_tbdac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (poll.valid),
    .in_ready  (poll.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_angle (result.angle),
    .out_up    (result.up_press),
    .out_down  (result.down_press)
);

`default_nettype wire
